FILE: rtl/ple_pkg.sv
package ple_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int DATA_W   = 32;
   localparam int OUT_CNT_W = 5;

   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [CMP_W-1:0] cmp_type;

   typedef enum logic [2:0] {
      FN_INS_END   = 3'd0,
      FN_INS_FRONT = 3'd1,
      FN_INS_AT    = 3'd2,
      FN_READ      = 3'd3,
      FN_DEL_FRONT = 3'd4,
      FN_DEL_END   = 3'd5,
      FN_DEL_AT    = 3'd6,
      FN_NOP       = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef struct packed {
      func_type                 func;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      status_type               status;
      logic [OUT_CNT_W-1:0]     entry_count;
   } rsp_type;

   // Broadcast to every cell of the chain.
   typedef struct packed {
      logic    ins;
      logic    del;
      cnt_type at;
   } cell_op_type;

endpackage

FILE: rtl/ple_cell.sv
module ple_cell (
   input  logic                               clock,
   input  ple_pkg::cell_op_type               op,
   input  ple_pkg::cnt_type                   index,
   input  logic signed [ple_pkg::DATA_W-1:0]  new_value,
   input  logic signed [ple_pkg::DATA_W-1:0]  left_value,
   input  logic signed [ple_pkg::DATA_W-1:0]  right_value,
   output logic signed [ple_pkg::DATA_W-1:0]  value,
   output logic signed [ple_pkg::DATA_W-1:0]  read_part
);

   logic signed [ple_pkg::DATA_W-1:0] value_ff;
   logic signed [ple_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      if (op.ins) begin
         if (index > op.at) begin
            value_in = left_value;
         end else if (index == op.at) begin
            value_in = new_value;
         end
      end else if (op.del) begin
         if (index >= op.at) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign read_part = (index == op.at) ? value_ff : '0;

endmodule

FILE: rtl/positional_list_engine.sv
// Ordered list of up to ple_pkg::CAPACITY signed 32-bit entries held in a chain
// of cells, one entry per cell, entry 0 at the head. Every request (insert,
// read or delete, by end, front or position) is applied at once: all cells shift
// toward or away from the addressed position at the same clock edge, so a new
// request is accepted each cycle while the result register is free. Each
// request returns one item with the value read, a status and the new count.
// Failing requests leave the list unchanged. No clearing pass follows reset.
module positional_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ple_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ple_pkg::rsp_type rsp_payload
);

   ple_pkg::cnt_type                  count_ff;
   ple_pkg::cnt_type                  count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   ple_pkg::rsp_type                  rsp_ff;
   ple_pkg::rsp_type                  rsp_in;

   logic                              accept;
   ple_pkg::cell_op_type              op;
   ple_pkg::status_type               op_status;
   logic                              op_read;
   logic                              full;
   logic                              empty;
   ple_pkg::cmp_type                  pos_w;
   ple_pkg::cmp_type                  cnt_w;
   logic signed [ple_pkg::DATA_W-1:0] read_data;

   logic signed [ple_pkg::DATA_W-1:0] cell_value [ple_pkg::CAPACITY];
   logic signed [ple_pkg::DATA_W-1:0] cell_read  [ple_pkg::CAPACITY];

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign full  = (count_ff == ple_pkg::cnt_type'(ple_pkg::CAPACITY));
   assign empty = (count_ff == '0);
   assign pos_w = ple_pkg::cmp_type'(req_payload.position);
   assign cnt_w = ple_pkg::cmp_type'(count_ff);

   always_comb begin
      op.ins    = 1'b0;
      op.del    = 1'b0;
      op.at     = ple_pkg::cnt_type'(req_payload.position);
      op_status = ple_pkg::ST_OK;
      op_read   = 1'b0;
      count_in  = count_ff;
      case (req_payload.func)
         ple_pkg::FN_INS_END: begin
            op.at = count_ff;
            if (full) begin
               op_status = ple_pkg::ST_FULL;
            end else begin
               op.ins = 1'b1;
            end
         end
         ple_pkg::FN_INS_FRONT: begin
            op.at = '0;
            if (full) begin
               op_status = ple_pkg::ST_FULL;
            end else begin
               op.ins = 1'b1;
            end
         end
         ple_pkg::FN_INS_AT: begin
            if (pos_w > cnt_w) begin
               op_status = ple_pkg::ST_RANGE;
            end else if (full) begin
               op_status = ple_pkg::ST_FULL;
            end else begin
               op.ins = 1'b1;
            end
         end
         ple_pkg::FN_READ: begin
            if (pos_w >= cnt_w) begin
               op_status = ple_pkg::ST_RANGE;
            end else begin
               op_read = 1'b1;
            end
         end
         ple_pkg::FN_DEL_FRONT: begin
            op.at = '0;
            if (empty) begin
               op_status = ple_pkg::ST_EMPTY;
            end else begin
               op.del = 1'b1;
            end
         end
         ple_pkg::FN_DEL_END: begin
            // No live entry moves; the cells from the last entry up still shift and the count drops.
            op.at = count_ff - 1'b1;
            if (empty) begin
               op_status = ple_pkg::ST_EMPTY;
            end else begin
               op.del = 1'b1;
            end
         end
         ple_pkg::FN_DEL_AT: begin
            if (empty) begin
               op_status = ple_pkg::ST_EMPTY;
            end else if (pos_w >= cnt_w) begin
               op_status = ple_pkg::ST_RANGE;
            end else begin
               op.del = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (op.ins) begin
         count_in = count_ff + 1'b1;
      end else if (op.del) begin
         count_in = count_ff - 1'b1;
      end
      if (!accept) begin
         op.ins   = 1'b0;
         op.del   = 1'b0;
         count_in = count_ff;
      end
   end

   genvar i;
   generate
      for (i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
         logic signed [ple_pkg::DATA_W-1:0] left_value;
         logic signed [ple_pkg::DATA_W-1:0] right_value;
         if (i == 0) begin : g_head
            assign left_value = '0;
         end else begin : g_left
            assign left_value = cell_value[i-1];
         end
         if (i == ple_pkg::CAPACITY - 1) begin : g_tail
            assign right_value = '0;
         end else begin : g_right
            assign right_value = cell_value[i+1];
         end
         ple_cell u_cell (
            .clock       (clock),
            .op          (op),
            .index       (ple_pkg::cnt_type'(i)),
            .new_value   (req_payload.item_value),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .read_part   (cell_read[i])
         );
      end
   endgenerate

   // Only the addressed cell drives a nonzero read part.
   always_comb begin
      read_data = '0;
      for (int k = 0; k < ple_pkg::CAPACITY; k++) begin
         read_data = read_data | cell_read[k];
      end
   end

   always_comb begin
      rsp_in.read_value  = op_read ? read_data : '0;
      rsp_in.status      = op_status;
      rsp_in.entry_count = ple_pkg::OUT_CNT_W'(count_in);
      rsp_valid_in       = rsp_valid_ff & rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ple_pkg::cnt_type'(ple_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_fail_keeps: assert property (@(posedge clock) disable iff (reset)
      (accept && op_status != ple_pkg::ST_OK) |=> $stable(count_ff))
      else $error("failed request changed the count");

   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && op.ins) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not grow the list by one");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ff.entry_count == ple_pkg::OUT_CNT_W'(count_ff))
      else $error("reported count differs from stored count");
`endif

endmodule
